// ----- hdl/vfsc_pkg.sv -----
// Package for the view frustum sphere cull block.
// Shared parameter defaults and fixed-point format constants.
// No dependencies.
`default_nettype none

package vfsc_pkg;

  localparam int ELEMENT_WIDTH_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 24;

  localparam int NUM_PLANES = 6;
  localparam int NUM_ROWS   = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam int COORD_FRAC = 12;
  localparam int SCALE_FRAC = 18;
  localparam int NORM_BITS  = 14;
  localparam int NORM_FRAC  = 12;
  localparam int OFS_BITS   = 22;
  localparam int OFS_FRAC   = 8;
  localparam int SCALE_W    = 32;

  localparam logic [SCALE_W-1:0] SCALE_SAT = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- hdl/view_frustum_sphere_cull.sv -----
// Sphere against view frustum test with cached clip planes.
// Derives six normalized planes from the matrix rows after each register
// write. Depends on vfsc_pkg.
//
// channel   direction  handshake               payload
// command   in         start && !busy          center_x/y/z, sphere_radius
// result    out        done (one cycle)        inside_res
// config    in         psel&penable&pwrite     paddr, pwdata (64-bit rows)
//
// One sphere is taken every cycle while busy is low; its word appears on done
// after the input register, product register and result register.
// After a register write busy stays high while the plane sequencer runs the
// length, square, check, divider (QW = 2*(ELEMENT_WIDTH-4)+37 quotient bits),
// square root (NI = (QW+1)/2 steps) and multiply states for each plane; planes
// whose normal has zero length skip the divider and the square root.
// rst is synchronous; it clears the rows, the sequencer and the strobes.
// The receiver cannot stall: each result is valid for its single cycle.
`default_nettype none

module view_frustum_sphere_cull
  import vfsc_pkg::*;
#(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] center_x,
  input  wire logic signed [COORD_WIDTH-1:0] center_y,
  input  wire logic signed [COORD_WIDTH-1:0] center_z,
  input  wire logic        [COORD_WIDTH-2:0] sphere_radius,
  output logic                               done,
  output logic                               inside_res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic        [CFG_ADDR_W-1:0]  paddr,
  input  wire logic        [CFG_DATA_W-1:0]  pwdata,
  output logic             [CFG_DATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int F    = ELEMENT_WIDTH - 4;
  localparam int TW   = ELEMENT_WIDTH + 1;
  localparam int LW   = 2 * TW + 2;
  localparam int QW   = 2 * F + 37;
  localparam int NI   = (QW + 1) / 2;
  localparam int RW   = QW + 1;
  localparam int DCW  = $clog2(QW);
  localparam int SCW  = $clog2(NI);
  localparam int PW   = TW + SCALE_W + 1;
  localparam int NSH  = F + SCALE_FRAC - NORM_FRAC;
  localparam int OSH  = F + SCALE_FRAC - OFS_FRAC;
  localparam int PRW  = NORM_BITS + COORD_WIDTH;
  localparam int OFS_SHIFT = NORM_FRAC + COORD_FRAC - OFS_FRAC;
  localparam int SUMW = (COORD_WIDTH + 17 > 39) ? COORD_WIDTH + 17 : 39;

  localparam logic signed [PW:0] N_HI  = (PW+1)'(2**(NORM_BITS-1) - 1);
  localparam logic signed [PW:0] N_LO  = (PW+1)'(-(2**(NORM_BITS-1)));
  localparam logic signed [PW:0] O_HI  = (PW+1)'(2**(OFS_BITS-1) - 1);
  localparam logic signed [PW:0] O_LO  = (PW+1)'(-(2**(OFS_BITS-1)));
  localparam logic signed [PW:0] N_RND = (PW+1)'(1) <<< (NSH - 1);
  localparam logic signed [PW:0] O_RND = (PW+1)'(1) <<< (OSH - 1);
  localparam logic [RW-1:0]      S_TOP = RW'(1) << (2 * (NI - 1));

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_SQ, S_CHK, S_DIV, S_SQI, S_SQRT, S_MUL
  } seq_state_t;

  // S_MUL alternates with the rounding step through rnd_phase
  seq_state_t state;
  logic       rnd_phase;

  logic [CFG_DATA_W-1:0] rows [NUM_ROWS];
  logic                  cfg_wr;

  logic [2:0]              pidx;
  logic [1:0]              jidx;
  logic signed [TW-1:0]    t_reg [4];
  logic [LW-1:0]           len2;
  logic [LW-1:0]           rem;
  logic [QW-1:0]           quo;
  logic [DCW-1:0]          dcnt;
  logic [RW-1:0]           sv, sres, sbit;
  logic [SCW-1:0]          scnt;
  logic [SCALE_W-1:0]      scale;
  logic signed [PW-1:0]    prod;

  logic signed [NORM_BITS-1:0] nrm_q [NUM_PLANES][3];
  logic signed [OFS_BITS-1:0]  ofs_q [NUM_PLANES];

  // sequencer datapath
  logic signed [TW-1:0]   t_next [4];
  logic [LW-1:0]          len2_next;
  logic [LW:0]            d_shift;
  logic                   d_ge;
  logic [LW-1:0]          d_rem_next;
  logic [RW-1:0]          s_trial, sv_next, sres_next;
  logic                   s_ge;
  logic signed [PW:0]     rnd_n, rnd_o, sh_n, sh_o, sat_n, sat_o;
  logic [CFG_DATA_W-1:0]  src_row;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign prdata = rows[paddr[4:3]];

  always_comb begin
    src_row = rows[pidx[2:1]];
    for (int j = 0; j < 4; j++) begin
      if (pidx[0]) begin
        t_next[j] = TW'($signed(rows[3][j*ELEMENT_WIDTH +: ELEMENT_WIDTH]))
                  + TW'($signed(src_row[j*ELEMENT_WIDTH +: ELEMENT_WIDTH]));
      end else begin
        t_next[j] = TW'($signed(rows[3][j*ELEMENT_WIDTH +: ELEMENT_WIDTH]))
                  - TW'($signed(src_row[j*ELEMENT_WIDTH +: ELEMENT_WIDTH]));
      end
    end
    len2_next = {2'b00, $unsigned((2*TW)'(t_reg[0]) * (2*TW)'(t_reg[0]))}
              + {2'b00, $unsigned((2*TW)'(t_reg[1]) * (2*TW)'(t_reg[1]))}
              + {2'b00, $unsigned((2*TW)'(t_reg[2]) * (2*TW)'(t_reg[2]))};

    // restoring divide of a single set numerator bit by len2
    d_shift    = {rem, (dcnt == DCW'(QW - 1))};
    d_ge       = d_shift >= {1'b0, len2};
    d_rem_next = d_ge ? LW'(d_shift - {1'b0, len2}) : d_shift[LW-1:0];

    s_trial   = sres + sbit;
    s_ge      = sv >= s_trial;
    sv_next   = s_ge ? sv - s_trial : sv;
    sres_next = s_ge ? (sres >> 1) + sbit : sres >> 1;

    rnd_n = (PW+1)'(prod) + N_RND;
    rnd_o = (PW+1)'(prod) + O_RND;
    sh_n  = rnd_n >>> NSH;
    sh_o  = rnd_o >>> OSH;
    sat_n = (sh_n > N_HI) ? N_HI : ((sh_n < N_LO) ? N_LO : sh_n);
    sat_o = (sh_o > O_HI) ? O_HI : ((sh_o < O_LO) ? O_LO : sh_o);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd_phase <= 1'b0;
      pidx      <= '0;
      jidx      <= '0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        rows[i] <= '0;
      end
    end else if (cfg_wr) begin
      // restart the plane pass on every write
      rows[paddr[4:3]] <= pwdata;
      state            <= S_LEN;
      rnd_phase        <= 1'b0;
      pidx             <= '0;
      jidx             <= '0;
    end else begin
      unique case (state)
        S_IDLE: ;
        S_LEN: begin
          for (int j = 0; j < 4; j++) begin
            t_reg[j] <= t_next[j];
          end
          state <= S_SQ;
        end
        S_SQ: begin
          len2  <= len2_next;
          state <= S_CHK;
        end
        S_CHK: begin
          jidx      <= '0;
          rnd_phase <= 1'b0;
          if (len2 == '0) begin
            scale <= SCALE_SAT;
            state <= S_MUL;
          end else begin
            rem   <= '0;
            dcnt  <= DCW'(QW - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= d_rem_next;
          quo  <= {quo[QW-2:0], d_ge};
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            state <= S_SQI;
          end
        end
        S_SQI: begin
          sv    <= RW'(quo);
          sres  <= '0;
          sbit  <= S_TOP;
          scnt  <= SCW'(NI - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          sv   <= sv_next;
          sres <= sres_next;
          sbit <= sbit >> 2;
          scnt <= scnt - 1'b1;
          if (scnt == '0) begin
            scale <= SCALE_W'(sres_next);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (!rnd_phase) begin
            prod      <= t_reg[jidx] * $signed({1'b0, scale});
            rnd_phase <= 1'b1;
          end else begin
            rnd_phase <= 1'b0;
            if (jidx == 2'd3) begin
              ofs_q[pidx] <= sat_o[OFS_BITS-1:0];
              if (pidx == 3'(NUM_PLANES - 1)) begin
                state <= S_IDLE;
              end else begin
                pidx  <= pidx + 1'b1;
                state <= S_LEN;
              end
            end else begin
              nrm_q[pidx][jidx] <= sat_n[NORM_BITS-1:0];
              jidx              <= jidx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // test pipeline: input register, product register, result register
  logic                          valid1, valid2;
  logic signed [COORD_WIDTH-1:0] c1 [3];
  logic        [COORD_WIDTH-2:0] r1, r2;
  logic signed [PRW-1:0]         prod2 [NUM_PLANES][3];
  logic signed [SUMW-1:0]        psum [NUM_PLANES];
  logic [NUM_PLANES-1:0]         pass;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      psum[p] = SUMW'(prod2[p][0]) + SUMW'(prod2[p][1]) + SUMW'(prod2[p][2])
              + (SUMW'(ofs_q[p]) <<< OFS_SHIFT)
              + ($signed(SUMW'({1'b0, r2})) <<< NORM_FRAC);
      pass[p] = (psum[p] > $signed(SUMW'(0)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= start && !busy;
      valid2 <= valid1;
      done   <= valid2;
    end
    c1[0] <= center_x;
    c1[1] <= center_y;
    c1[2] <= center_z;
    r1    <= sphere_radius;
    r2    <= r1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int j = 0; j < 3; j++) begin
        prod2[p][j] <= nrm_q[p][j] * c1[j];
      end
    end
    inside_res <= &pass;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##2 done)
    else $error("accepted sphere gave no result word");
  a_busy_after_wr: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy)
    else $error("register write did not start the plane pass");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (len2 != '0))
    else $error("divider running on a zero-length normal");
  a_plane_idx: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pidx < 3'(NUM_PLANES)))
    else $error("plane index out of range");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid1, 2))
    else $error("result word without an accepted sphere");
`endif

endmodule

`default_nettype wire
